>>> design/wcssd_pkg.sv
// Shared types and constants of the weighted channel SSD distance block.
package wcssd_pkg;

   localparam int unsigned NUM_CH     = 3;
   localparam int unsigned CH_W       = 2;
   localparam int unsigned SAMPLE_W   = 8;
   localparam int unsigned SQ_W       = 2 * SAMPLE_W;
   localparam int unsigned SUM_W      = 40;
   localparam int unsigned COUNT_W    = 18;
   localparam int unsigned MAX_PIXELS = 131072;
   localparam int unsigned DIST_W     = 24;
   localparam int unsigned ROOT_W     = 32;
   localparam int unsigned REM_W      = ROOT_W + 2;
   localparam int unsigned WSUM_W     = ROOT_W + 3;
   localparam int unsigned DQ_W       = WSUM_W + 4;
   localparam int unsigned DEN_W      = COUNT_W + 2;
   localparam int unsigned STEP_W     = 6;
   localparam int unsigned SQRT_STEPS = ROOT_W;
   localparam int unsigned DIV_STEPS  = DQ_W;

   localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(16711680);

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [SUM_W-1:0]    sum_type;

   typedef struct packed {
      sample_type [NUM_CH-1:0] first;
      sample_type [NUM_CH-1:0] second;
   } pixel_type;

   typedef struct packed {
      logic update;
      logic clear;
   } accum_ctl_type;

   typedef struct packed {
      logic             ge;
      logic [REM_W-1:0] diff;
   } subcmp_type;

endpackage

>>> design/wcssd_subcmp.sv
// Shared compare-subtract unit for the root and division steps.
module wcssd_subcmp (
   input  logic [wcssd_pkg::REM_W-1:0] a,
   input  logic [wcssd_pkg::REM_W-1:0] b,
   output wcssd_pkg::subcmp_type       res
);
   import wcssd_pkg::*;

   logic [REM_W:0] wide_diff;

   assign wide_diff = {1'b0, a} - {1'b0, b};
   assign res.ge    = ~wide_diff[REM_W];
   assign res.diff  = wide_diff[REM_W-1:0];

endmodule

>>> design/wcssd_accum.sv
// Per-channel squared-difference accumulators and pixel counter.
module wcssd_accum (
   input  logic                                clock,
   input  logic                                reset,
   input  wcssd_pkg::accum_ctl_type            ctl,
   input  wcssd_pkg::pixel_type                pixel,
   output wcssd_pkg::sum_type [wcssd_pkg::NUM_CH-1:0] sums,
   output logic [wcssd_pkg::COUNT_W-1:0]       count
);
   import wcssd_pkg::*;

   sum_type [NUM_CH-1:0] sums_ff, sums_in;
   logic [COUNT_W-1:0]   count_ff;
   logic                 room;
   sample_type           diff [NUM_CH];
   logic [SQ_W-1:0]      sq   [NUM_CH];

   assign room = count_ff < COUNT_W'(MAX_PIXELS);

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         diff[c] = (pixel.first[c] >= pixel.second[c]) ?
                   (pixel.first[c] - pixel.second[c]) :
                   (pixel.second[c] - pixel.first[c]);
         sq[c]      = diff[c] * diff[c];
         sums_in[c] = sums_ff[c] + SUM_W'(sq[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         sums_ff  <= '0;
         count_ff <= '0;
      end else if (ctl.update && room) begin
         sums_ff  <= sums_in;
         count_ff <= count_ff + COUNT_W'(1);
      end
   end

   assign sums  = sums_ff;
   assign count = count_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_PIXELS))
      else $error("pixel count beyond limit");
   a_sums_hold: assert property (@(posedge clock) disable iff (reset)
      (!ctl.update && !ctl.clear) |=> $stable(sums_ff))
      else $error("sums changed without a request");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> (count_ff == '0 && sums_ff == '0))
      else $error("accumulators not cleared");
`endif

endmodule

>>> design/wcssd_eval.sv
// Sequencer for per-channel roots, weighted sum, division and result register.
module wcssd_eval (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   input  wcssd_pkg::sum_type [wcssd_pkg::NUM_CH-1:0] sums,
   input  logic [wcssd_pkg::COUNT_W-1:0]              count,
   input  logic                                       rsp_ready,
   output logic                                       idle,
   output logic                                       clear,
   output logic                                       rsp_valid,
   output logic [wcssd_pkg::DIST_W-1:0]               rsp_distance_q16,
   output logic [wcssd_pkg::COUNT_W-1:0]              rsp_pixels_seen
);
   import wcssd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROOT,
      ST_NEXT,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CH_W-1:0]    ch_ff, ch_in;
   logic [STEP_W-1:0]  iter_ff, iter_in;
   sum_type            s_ff, s_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [WSUM_W-1:0]  w_ff, w_in;
   logic [DQ_W-1:0]    dq_ff, dq_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic [COUNT_W-1:0] seen_ff, seen_in;

   logic [REM_W-1:0]   op_a, op_b;
   subcmp_type         unit;
   logic [WSUM_W-1:0]  weighted;
   logic [WSUM_W-1:0]  w_sum;
   logic               out_free;

   wcssd_subcmp u_subcmp (
      .a   (op_a),
      .b   (op_b),
      .res (unit)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign weighted = (ch_ff == CH_W'(NUM_CH - 1)) ? WSUM_W'(root_ff) :
                     WSUM_W'({root_ff, 1'b0});
   assign w_sum    = w_ff + weighted;

   always_comb begin
      unique case (state_ff)
         ST_ROOT: begin
            op_a = {rem_ff[REM_W-3:0], s_ff[SUM_W-1 -: 2]};
            op_b = {root_ff, 2'b01};
         end
         ST_DIV: begin
            op_a = REM_W'({rem_ff[DEN_W-1:0], dq_ff[DQ_W-1]});
            op_b = REM_W'(den_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      iter_in      = iter_ff;
      s_in         = s_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      w_in         = w_ff;
      dq_in        = dq_ff;
      den_in       = den_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      dist_in      = dist_ff;
      seen_in      = seen_ff;
      clear        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ch_in    = '0;
               w_in     = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            s_in     = sums[ch_ff];
            rem_in   = '0;
            root_in  = '0;
            iter_in  = '0;
            den_in   = DEN_W'({count, 2'b00}) + DEN_W'(count);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rem_in  = unit.ge ? unit.diff : op_a;
            root_in = {root_ff[ROOT_W-2:0], unit.ge};
            s_in    = {s_ff[SUM_W-3:0], 2'b00};
            iter_in = iter_ff + STEP_W'(1);
            if (iter_ff == STEP_W'(SQRT_STEPS - 1)) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            w_in = w_sum;
            if (ch_ff == CH_W'(NUM_CH - 1)) begin
               dq_in    = {w_sum, 4'b0000};
               rem_in   = '0;
               iter_in  = '0;
               state_in = ST_DIV;
            end else begin
               ch_in    = ch_ff + CH_W'(1);
               state_in = ST_LOAD;
            end
         end
         ST_DIV: begin
            rem_in  = unit.ge ? unit.diff : op_a;
            dq_in   = {dq_ff[DQ_W-2:0], unit.ge};
            iter_in = iter_ff + STEP_W'(1);
            if (iter_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               dist_in      = (dq_ff > DQ_W'(DIST_MAX)) ? DIST_MAX : dq_ff[DIST_W-1:0];
               seen_in      = count;
               clear        = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff   <= ch_in;
      iter_ff <= iter_in;
      s_ff    <= s_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      w_ff    <= w_in;
      dq_ff   <= dq_in;
      den_ff  <= den_in;
      dist_ff <= dist_in;
      seen_ff <= seen_in;
   end

   assign idle             = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_distance_q16 = dist_ff;
   assign rsp_pixels_seen  = seen_ff;

`ifndef ASSERT_OFF
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < REM_W'(den_ff)))
      else $error("division remainder not below divisor");
   a_dist_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (dist_ff <= DIST_MAX))
      else $error("distance beyond saturation limit");
   a_load_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result loaded outside completion");
`endif

endmodule

>>> design/weighted_channel_ssd_distance.sv
// Top level of the weighted channel SSD distance block.
//
//   channel  ports  direction  payload
//   request  req_   in         two 3-channel 8-bit pixels, last_pixel flag
//   result   rsp_   out        distance_q16 (Q8.16), pixels_seen
//
// Pixel pairs are taken one per cycle while the block is idle.
// A request marked last starts evaluation: ready stays low through three
// 32-step roots, each with a load and a weighting state, a 39-step division
// and a completion state; the roots and the division share the single
// compare-subtract unit.
// The result register frees the request side; a finished evaluation waits
// until that register is free. Reset is synchronous and clears sums and count.
module weighted_channel_ssd_distance (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [wcssd_pkg::SAMPLE_W-1:0]      req_first_ch0,
   input  logic [wcssd_pkg::SAMPLE_W-1:0]      req_first_ch1,
   input  logic [wcssd_pkg::SAMPLE_W-1:0]      req_first_ch2,
   input  logic [wcssd_pkg::SAMPLE_W-1:0]      req_second_ch0,
   input  logic [wcssd_pkg::SAMPLE_W-1:0]      req_second_ch1,
   input  logic [wcssd_pkg::SAMPLE_W-1:0]      req_second_ch2,
   input  logic                                req_last_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [wcssd_pkg::DIST_W-1:0]        rsp_distance_q16,
   output logic [wcssd_pkg::COUNT_W-1:0]       rsp_pixels_seen
);
   import wcssd_pkg::*;

   pixel_type            pixel;
   accum_ctl_type        ctl;
   sum_type [NUM_CH-1:0] sums;
   logic [COUNT_W-1:0]   count;
   logic                 accept;
   logic                 idle;
   logic                 clear;

   assign pixel.first  = {req_first_ch2, req_first_ch1, req_first_ch0};
   assign pixel.second = {req_second_ch2, req_second_ch1, req_second_ch0};

   assign req_ready  = idle;
   assign accept     = req_valid && idle;
   assign ctl.update = accept;
   assign ctl.clear  = clear;

   wcssd_accum u_accum (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .pixel (pixel),
      .sums  (sums),
      .count (count)
   );

   wcssd_eval u_eval (
      .clock            (clock),
      .reset            (reset),
      .start            (accept && req_last_pixel),
      .sums             (sums),
      .count            (count),
      .rsp_ready        (rsp_ready),
      .idle             (idle),
      .clear            (clear),
      .rsp_valid        (rsp_valid),
      .rsp_distance_q16 (rsp_distance_q16),
      .rsp_pixels_seen  (rsp_pixels_seen)
   );

endmodule
